/* hdl/mcpt_pkg.sv */
// Shared definitions for the multi-channel periodic timer.
// Command and status codes, default sizes, and the controller/datapath link types.
// No dependencies.
package mcpt_pkg;

    localparam int MAX_TIMERS_DEF = 16;
    localparam int ID_BITS_DEF    = 8;

    localparam int CMD_W      = 3;
    localparam int IN_ID_W    = 8;
    localparam int PERIOD_W   = 32;
    localparam int DELTA_W    = 16;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic start;   // latch the incoming beat, rewind the slot scan
        logic step;    // evaluate the current slot and advance
        logic finish;  // apply the command and load the closing result
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_needed;  // incoming command visits every slot
        logic last_slot;    // scan index sits on the final slot
        logic slot_hold;    // current slot cannot retire yet
        logic out_free;     // output register can take a beat now
    } stat_t;

endpackage

/* hdl/mcpt_dp.sv */
// Datapath of the multi-channel periodic timer: slot table, scan index,
// tick arithmetic, pending fire and output register. Depends on mcpt_pkg.
module mcpt_dp
    import mcpt_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [IN_ID_W-1:0]  timer_id,
    input  logic [PERIOD_W-1:0] period,
    input  logic [DELTA_W-1:0]  delta,
    input  ctl_t                ctl,
    output stat_t               stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                fired,
    output logic [IN_ID_W-1:0]  fired_id,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TIMERS - 1);

    // slot table storage
    logic [ID_BITS-1:0]  id_mem      [MAX_TIMERS];
    logic [PERIOD_W-1:0] period_mem  [MAX_TIMERS];
    logic [PERIOD_W-1:0] elapsed_mem [MAX_TIMERS];
    logic [ID_BITS-1:0]  id_rd;
    logic [PERIOD_W-1:0] period_rd;
    logic [PERIOD_W-1:0] elapsed_rd;

    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [MAX_TIMERS-1:0] paused_reg, paused_next;

    // latched command
    logic [CMD_W-1:0]    cmd_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DELTA_W-1:0]  delta_reg;

    logic [IDX_W-1:0] idx_reg, idx_next, idx_inc, rd_addr, wr_addr;
    logic             match_reg, match_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0] pend_id_reg, pend_id_next;

    logic                out_valid_reg, out_valid_next;
    logic                fired_reg, fired_next;
    logic [ID_BITS-1:0]  fid_reg, fid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                last_reg, last_next;
    logic                out_load;

    // tick arithmetic
    logic                slot_active;
    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W-1:0] sat;
    logic [PERIOD_W:0]   diff;
    logic                slot_fire;
    logic [PERIOD_W-1:0] new_elapsed;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] tgt_idx;
    logic             tgt_ok;
    logic             is_tick, is_add;
    logic             id_we, elapsed_we;
    logic [PERIOD_W-1:0] elapsed_wdata;

    assign is_tick = (cmd_reg == CMD_TICK);
    assign is_add  = (cmd_reg == CMD_ADD);

    assign slot_active = valid_reg[idx_reg] & ~paused_reg[idx_reg];
    assign sum         = {1'b0, elapsed_rd} + (PERIOD_W+1)'(delta_reg);
    assign sat         = sum[PERIOD_W] ? {PERIOD_W{1'b1}} : sum[PERIOD_W-1:0];
    assign diff        = {1'b0, sat} - {1'b0, period_rd};
    assign slot_fire   = is_tick & slot_active & ~diff[PERIOD_W];
    assign new_elapsed = slot_fire ? diff[PERIOD_W-1:0] : sat;

    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign tgt_idx = match_reg ? match_idx_reg : free_idx;
    assign tgt_ok  = match_reg | free_found;

    // status to controller
    always_comb
    begin
        stat.scan_needed = (cmd inside {CMD_TICK, CMD_ADD, CMD_DELETE});
        stat.last_slot   = (idx_reg == IDX_LAST);
        stat.out_free    = ~out_valid_reg | out_ready;
        stat.slot_hold   = slot_fire & pend_valid_reg & ~stat.out_free;
    end

    // memory port addressing
    always_comb
    begin
        if (ctl.start)
            rd_addr = '0;
        else if (ctl.step)
            rd_addr = idx_inc;
        else
            rd_addr = idx_reg;
        wr_addr       = ctl.finish ? tgt_idx : idx_reg;
        id_we         = ctl.finish & is_add & tgt_ok;
        elapsed_we    = id_we | (ctl.step & is_tick & slot_active);
        elapsed_wdata = ctl.finish ? '0 : new_elapsed;
    end

    always_ff @(posedge clk)
    begin
        id_rd      <= id_mem[rd_addr];
        period_rd  <= period_mem[rd_addr];
        elapsed_rd <= elapsed_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_addr]     <= id_reg;
            period_mem[wr_addr] <= period_reg;
        end
        if (elapsed_we)
            elapsed_mem[wr_addr] <= elapsed_wdata;
    end

    // scan, table flags and result selection
    always_comb
    begin
        idx_next        = idx_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        valid_next      = valid_reg;
        paused_next     = paused_reg;
        out_load        = 1'b0;
        fired_next      = fired_reg;
        fid_next        = fid_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        if (ctl.start)
        begin
            idx_next        = '0;
            match_next      = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (ctl.step)
        begin
            idx_next = idx_inc;
            if (!match_reg && valid_reg[idx_reg] && id_rd == id_reg)
            begin
                match_next     = 1'b1;
                match_idx_next = idx_reg;
            end
            if (slot_fire)
            begin
                // release the previous fire, hold this one until we know if it closes the item
                if (pend_valid_reg)
                begin
                    out_load    = 1'b1;
                    fired_next  = 1'b1;
                    fid_next    = pend_id_reg;
                    status_next = STS_OK;
                    last_next   = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = id_rd;
            end
        end

        if (ctl.finish)
        begin
            out_load    = 1'b1;
            fired_next  = 1'b0;
            fid_next    = '0;
            status_next = STS_OK;
            last_next   = 1'b1;
            case (cmd_reg)
                CMD_TICK:
                begin
                    fired_next      = pend_valid_reg;
                    fid_next        = pend_valid_reg ? pend_id_reg : '0;
                    pend_valid_next = 1'b0;
                end
                CMD_ADD:
                begin
                    if (tgt_ok)
                    begin
                        valid_next[tgt_idx]  = 1'b1;
                        paused_next[tgt_idx] = 1'b0;
                    end
                    else
                        status_next = STS_FULL;
                end
                CMD_DELETE:
                begin
                    if (match_reg)
                        valid_next[match_idx_reg] = 1'b0;
                    else
                        status_next = STS_NOT_FOUND;
                end
                CMD_PAUSE:  paused_next = '1;
                CMD_RESUME: paused_next = '0;
                default:    ;
            endcase
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            match_reg      <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            match_reg      <= match_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg    <= cmd;
            id_reg     <= ID_BITS'(timer_id);
            period_reg <= period;
            delta_reg  <= delta;
        end
        paused_reg    <= paused_next;
        match_idx_reg <= match_idx_next;
        pend_id_reg   <= pend_id_next;
        fired_reg     <= fired_next;
        fid_reg       <= fid_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign fired     = fired_reg;
    assign fired_id  = IN_ID_W'(fid_reg);
    assign status    = status_reg;
    assign last      = last_reg;

    // a new beat never overwrites one the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");

    // closing the item always leaves a final beat in the output register
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (out_valid_reg && last_reg))
        else $error("finish did not load a final beat");

    // a beat loaded mid-scan is always a fire that is not final
    a_scan_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !ctl.finish) |=> (fired_reg && !last_reg))
        else $error("scan beat is not a non-final fire");

endmodule

/* hdl/mcpt_ctrl.sv */
// Controller of the multi-channel periodic timer: accept, slot scan, finish.
// Drives the datapath through ctl_t and reads stat_t. Depends on mcpt_pkg.
module mcpt_ctrl
    import mcpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = stat.scan_needed ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (!stat.slot_hold)
                begin
                    ctl.step = 1'b1;
                    if (stat.last_slot)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // the scan leaves for finish right after stepping off the final slot
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !stat.slot_hold && stat.last_slot)
            |=> state_reg == ST_FINISH)
        else $error("scan did not end on final slot");

    // a held slot keeps the scan in place
    a_hold_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.slot_hold) |=> state_reg == ST_SCAN)
        else $error("scan left while slot held");

endmodule

/* hdl/multi_channel_periodic_timer_top.sv */
// Top level of the multi-channel periodic timer.
// Joins mcpt_ctrl and mcpt_dp; depends on mcpt_pkg.
//
//  channel  | direction | handshake            | beat contents
//  ---------+-----------+----------------------+------------------------------------
//  command  | in        | in_valid / in_ready  | cmd, timer_id, period, delta
//  result   | out       | out_valid / out_ready| fired, fired_id, status, last
//
// Sequence: tick, add and delete run accept, a scan step for each slot and result load;
// pause, resume and unknown codes go from accept straight to result load. The scan
// runs through the single read port of the slot table memory.
// Reset: rst_n clears the slot valid bits, scan index and handshake flags, not the pause bits; no clearing pass.
// Stalls: a held result blocks the scan only when a second fire needs to leave;
// a new command is taken while the final beat of the previous one waits.
module multi_channel_periodic_timer_top
    import mcpt_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [IN_ID_W-1:0]  timer_id,
    input  logic [PERIOD_W-1:0] period,
    input  logic [DELTA_W-1:0]  delta,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                fired,
    output logic [IN_ID_W-1:0]  fired_id,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    ctl_t  ctl;
    stat_t stat;

    // sequencing: idle, scan of every slot for tick, add and delete, finish
    mcpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // slot table, tick arithmetic and output register
    mcpt_dp #(
        .MAX_TIMERS (MAX_TIMERS),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .timer_id  (timer_id),
        .period    (period),
        .delta     (delta),
        .ctl       (ctl),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .fired     (fired),
        .fired_id  (fired_id),
        .status    (status),
        .last      (last)
    );

endmodule
